>>> hdl/pee_pkg.sv
`default_nettype none

package pee_pkg;

  localparam int unsigned DATA_W = 32;
  localparam int unsigned NUM_VARS = 6;
  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned LEFT_W = 7;

  typedef logic [2:0] cmd_t;

  localparam cmd_t CMD_PUSH = 3'd0;
  localparam cmd_t CMD_ADD  = 3'd1;
  localparam cmd_t CMD_SUB  = 3'd2;
  localparam cmd_t CMD_MUL  = 3'd3;
  localparam cmd_t CMD_DIV  = 3'd4;
  localparam cmd_t CMD_POW  = 3'd5;

  typedef logic [1:0] status_t;

  localparam status_t ST_OK    = 2'd0;
  localparam status_t ST_OVER  = 2'd1;
  localparam status_t ST_UNDER = 2'd2;
  localparam status_t ST_DIVZ  = 2'd3;

  typedef struct packed {
    logic start;
    cmd_t op;
  } alu_req_t;

  typedef struct packed {
    logic done;
    logic div_zero;
  } alu_rsp_t;

endpackage

`default_nettype wire

>>> hdl/pee_stack.sv
`default_nettype none

module pee_stack
  import pee_pkg::*;
#(
  parameter int unsigned DEPTH  = 64,
  parameter int unsigned ADDR_W = 6
) (
  input  logic                clk,
  input  logic                wr_en,
  input  logic [ADDR_W-1:0]   wr_addr,
  input  logic [DATA_W-1:0]   wr_data,
  input  logic                rd_en,
  input  logic [ADDR_W-1:0]   rd_addr,
  output logic [DATA_W-1:0]   rd_data
);

  logic [DATA_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Read data holds until the next read, so the sequencer can wait on it.
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

>>> hdl/pee_alu.sv
`default_nettype none

module pee_alu
  import pee_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  alu_req_t          req,
  input  logic [DATA_W-1:0] opa,
  input  logic [DATA_W-1:0] opb,
  output alu_rsp_t          rsp,
  output logic [DATA_W-1:0] result
);

  typedef enum logic [4:0] {
    AL_IDLE = 5'b00001,
    AL_DIV  = 5'b00010,
    AL_FIX  = 5'b00100,
    AL_POWM = 5'b01000,
    AL_POWS = 5'b10000
  } alu_state_t;

  alu_state_t state;
  logic [DATA_W-1:0] quo;
  logic [DATA_W-1:0] rem;
  logic [DATA_W-1:0] dvs;
  logic [4:0]        cnt;
  logic              neg;
  logic [DATA_W-1:0] acc;
  logic [DATA_W-1:0] base;
  logic [DATA_W-1:0] ex;

  logic [DATA_W-1:0] mul_x;
  logic [DATA_W-1:0] mul_y;
  logic [DATA_W-1:0] prod;
  logic [DATA_W:0]   rem_sh;
  logic [DATA_W:0]   diff;
  logic [DATA_W-1:0] mag_a;
  logic [DATA_W-1:0] mag_b;

  // The single multiplier is shared by multiply and both power phases.
  always_comb begin
    unique case (state)
      AL_POWM: begin
        mul_x = acc;
        mul_y = base;
      end
      AL_POWS: begin
        mul_x = base;
        mul_y = base;
      end
      default: begin
        mul_x = opa;
        mul_y = opb;
      end
    endcase
  end

  assign prod   = mul_x * mul_y;
  assign rem_sh = {rem, quo[DATA_W-1]};
  assign diff   = rem_sh - {1'b0, dvs};
  assign mag_a  = opa[DATA_W-1] ? (~opa + 1'b1) : opa;
  assign mag_b  = opb[DATA_W-1] ? (~opb + 1'b1) : opb;

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= AL_IDLE;
      rsp.done     <= 1'b0;
      rsp.div_zero <= 1'b0;
    end else begin
      rsp.done     <= 1'b0;
      rsp.div_zero <= 1'b0;
      unique case (state)
        AL_IDLE: begin
          if (req.start) begin
            unique case (req.op)
              CMD_ADD: begin
                result   <= opa + opb;
                rsp.done <= 1'b1;
              end
              CMD_SUB: begin
                result   <= opa - opb;
                rsp.done <= 1'b1;
              end
              CMD_DIV: begin
                if (opb == '0) begin
                  result       <= '0;
                  rsp.done     <= 1'b1;
                  rsp.div_zero <= 1'b1;
                end else begin
                  quo   <= mag_a;
                  rem   <= '0;
                  dvs   <= mag_b;
                  neg   <= opa[DATA_W-1] ^ opb[DATA_W-1];
                  cnt   <= '1;
                  state <= AL_DIV;
                end
              end
              CMD_POW: begin
                // A zero or negative exponent gives one.
                if (opb[DATA_W-1] || opb == '0) begin
                  result   <= DATA_W'(1);
                  rsp.done <= 1'b1;
                end else begin
                  acc   <= DATA_W'(1);
                  base  <= opa;
                  ex    <= opb;
                  state <= AL_POWM;
                end
              end
              default: begin
                result   <= prod;
                rsp.done <= 1'b1;
              end
            endcase
          end
        end
        AL_DIV: begin
          if (!diff[DATA_W]) begin
            rem <= diff[DATA_W-1:0];
            quo <= {quo[DATA_W-2:0], 1'b1};
          end else begin
            rem <= rem_sh[DATA_W-1:0];
            quo <= {quo[DATA_W-2:0], 1'b0};
          end
          cnt <= cnt - 1'b1;
          if (cnt == '0) begin
            state <= AL_FIX;
          end
        end
        AL_FIX: begin
          result   <= neg ? (~quo + 1'b1) : quo;
          rsp.done <= 1'b1;
          state    <= AL_IDLE;
        end
        AL_POWM: begin
          if (ex[0]) begin
            acc <= prod;
          end
          if (ex[DATA_W-1:1] == '0) begin
            result   <= ex[0] ? prod : acc;
            rsp.done <= 1'b1;
            state    <= AL_IDLE;
          end else begin
            state <= AL_POWS;
          end
        end
        AL_POWS: begin
          base  <= prod;
          ex    <= ex >> 1;
          state <= AL_POWM;
        end
        default: begin
          state <= AL_IDLE;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

>>> hdl/prefix_expression_evaluator_unit.sv
// Push writes the operand to the stack. Add, subtract and multiply pop both
// operands and push the result; divide runs through the bit-serial divider; power
// alternates multiply and square steps on the shared multiplier for each exponent
// bit up to the top set bit. A last request adds a final pop plus any wait for the
// result register to drain. Reset clears the stack count, sticky status and
// variable registers; stack memory keeps its contents and needs no clearing pass.
`default_nettype none

module prefix_expression_evaluator_unit
  import pee_pkg::*;
#(
  parameter int unsigned STACK_DEPTH = 64
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [2:0]                  command,
  input  logic [2:0]                  var_index,
  input  logic                        last,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic signed [DATA_W-1:0]    result_value,
  output logic [1:0]                  status,
  output logic [LEFT_W-1:0]           leftover_entries,
  input  logic                        cfg_write,
  input  logic [CFG_IDX_W-1:0]        cfg_index,
  input  logic [DATA_W-1:0]           cfg_data
);

  localparam int unsigned ADDR_W = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
  localparam int unsigned CNT_W  = $clog2(STACK_DEPTH + 1);

  typedef enum logic [7:0] {
    S_IDLE = 8'b00000001,
    S_PUSH = 8'b00000010,
    S_POPA = 8'b00000100,
    S_POPB = 8'b00001000,
    S_EXEC = 8'b00010000,
    S_WAIT = 8'b00100000,
    S_FPOP = 8'b01000000,
    S_FOUT = 8'b10000000
  } state_t;

  state_t            state;
  state_t            state_next;
  logic [CNT_W-1:0]  count;
  logic [CNT_W-1:0]  count_next;
  logic [CNT_W-1:0]  count_dec;
  status_t           sticky;
  status_t           sticky_next;
  logic [DATA_W-1:0] vars [NUM_VARS];
  cmd_t              cmd_q;
  logic              last_q;
  logic [DATA_W-1:0] push_val;
  logic [DATA_W-1:0] opa;
  logic [DATA_W-1:0] opb;
  logic              pop_ok;

  logic              in_take;
  logic              out_free;
  logic              pop_en;
  logic              flag_en;
  status_t           flag_code;
  logic              stack_empty;
  logic              stack_full;
  logic              wr_en;
  logic              rd_en;
  logic [DATA_W-1:0] rd_data;
  logic [DATA_W-1:0] var_sel;
  alu_req_t          alu_req;
  alu_rsp_t          alu_rsp;
  logic [DATA_W-1:0] alu_result;
  logic              load_out;

  assign in_stall    = (state != S_IDLE);
  assign in_take     = in_valid && !in_stall;
  assign out_free    = !out_valid || !out_stall;
  assign stack_empty = (count == '0);
  assign stack_full  = (count == CNT_W'(STACK_DEPTH));
  assign count_dec   = count - CNT_W'(1);
  assign var_sel     = (var_index < CFG_IDX_W'(NUM_VARS)) ? vars[var_index] : '0;
  assign opb         = pop_ok ? rd_data : '0;

  always_comb begin
    state_next = state;
    count_next = count;
    pop_en     = 1'b0;
    flag_en    = 1'b0;
    flag_code  = ST_OK;
    wr_en      = 1'b0;
    alu_req    = '0;
    load_out   = 1'b0;
    unique case (state)
      S_IDLE: begin
        if (in_take) begin
          priority if (command == CMD_PUSH) begin
            state_next = S_PUSH;
          end else if (command <= CMD_POW) begin
            state_next = S_POPA;
          end else if (last) begin
            state_next = S_FPOP;
          end else begin
            state_next = S_IDLE;
          end
        end
      end
      S_PUSH: begin
        if (stack_full) begin
          flag_en   = 1'b1;
          flag_code = ST_OVER;
        end else begin
          wr_en      = 1'b1;
          count_next = count + CNT_W'(1);
        end
        state_next = last_q ? S_FPOP : S_IDLE;
      end
      S_POPA: begin
        pop_en     = 1'b1;
        state_next = S_POPB;
      end
      S_POPB: begin
        pop_en     = 1'b1;
        state_next = S_EXEC;
      end
      S_EXEC: begin
        alu_req.start = 1'b1;
        alu_req.op    = cmd_q;
        state_next    = S_WAIT;
      end
      S_WAIT: begin
        if (alu_rsp.done) begin
          if (alu_rsp.div_zero) begin
            flag_en   = 1'b1;
            flag_code = ST_DIVZ;
          end
          state_next = S_PUSH;
        end
      end
      S_FPOP: begin
        pop_en     = 1'b1;
        state_next = S_FOUT;
      end
      S_FOUT: begin
        if (out_free) begin
          load_out   = 1'b1;
          count_next = '0;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase

    // A pop from an empty stack yields zero and raises underflow.
    if (pop_en) begin
      if (stack_empty) begin
        flag_en   = 1'b1;
        flag_code = ST_UNDER;
      end else begin
        count_next = count_dec;
      end
    end
  end

  assign rd_en = pop_en && !stack_empty;

  always_comb begin
    sticky_next = sticky;
    if (load_out) begin
      sticky_next = ST_OK;
    end else if (flag_en && sticky == ST_OK) begin
      sticky_next = flag_code;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      sticky    <= ST_OK;
      out_valid <= 1'b0;
      for (int i = 0; i < NUM_VARS; i++) begin
        vars[i] <= '0;
      end
    end else begin
      state  <= state_next;
      count  <= count_next;
      sticky <= sticky_next;
      if (load_out) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
      if (cfg_write && cfg_index < CFG_IDX_W'(NUM_VARS)) begin
        vars[cfg_index] <= cfg_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      cmd_q    <= command;
      last_q   <= last;
      push_val <= var_sel;
    end
    if (state == S_WAIT && alu_rsp.done) begin
      push_val <= alu_result;
    end
    if (pop_en) begin
      pop_ok <= !stack_empty;
    end
    if (state == S_POPB) begin
      opa <= pop_ok ? rd_data : '0;
    end
    if (load_out) begin
      result_value     <= pop_ok ? rd_data : '0;
      status           <= sticky;
      leftover_entries <= LEFT_W'(count);
    end
  end

  pee_stack #(
    .DEPTH  (STACK_DEPTH),
    .ADDR_W (ADDR_W)
  ) u_stack (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (count[ADDR_W-1:0]),
    .wr_data (push_val),
    .rd_en   (rd_en),
    .rd_addr (count_dec[ADDR_W-1:0]),
    .rd_data (rd_data)
  );

  pee_alu u_alu (
    .clk    (clk),
    .rst    (rst),
    .req    (alu_req),
    .opa    (opa),
    .opb    (opb),
    .rsp    (alu_rsp),
    .result (alu_result)
  );

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(STACK_DEPTH))
    else $error("stack count above depth");

  a_clear_after_result: assert property (@(posedge clk) disable iff (rst)
    load_out |=> (count == '0) && (sticky == ST_OK))
    else $error("stack or status not cleared after result");

  a_alu_done_in_wait: assert property (@(posedge clk) disable iff (rst)
    alu_rsp.done |-> (state == S_WAIT))
    else $error("arithmetic unit finished outside wait state");

  a_result_from_final: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state == S_FOUT))
    else $error("result raised outside the final pop");

  a_write_not_full: assert property (@(posedge clk) disable iff (rst)
    wr_en |-> !stack_full)
    else $error("stack write while full");

endmodule

`default_nettype wire

>>> sim/tb_prefix_expression_evaluator_unit.sv
module tb_prefix_expression_evaluator_unit;
  timeunit 1ns;
  timeprecision 1ps;

  import pee_pkg::*;

  localparam int unsigned STACK_DEPTH = 64;
  localparam int unsigned CYCLE_LIMIT = 1000000;
  localparam int unsigned SETTLE_CYCLES = 100;
  localparam int unsigned PHASES = 9;
  localparam int unsigned REQUESTS_PER_PHASE = 185;

  localparam cmd_t CMD_SPARE_LO = 3'd6;
  localparam cmd_t CMD_SPARE_HI = 3'd7;

  localparam logic [2:0] VAR_A = 3'd0;
  localparam logic [2:0] VAR_B = 3'd1;
  localparam logic [2:0] VAR_C = 3'd2;
  localparam logic [2:0] VAR_D = 3'd3;
  localparam logic [2:0] VAR_E = 3'd4;
  localparam logic [2:0] VAR_F = 3'd5;
  localparam logic [2:0] VAR_SPARE_LO = 3'd6;
  localparam logic [2:0] VAR_SPARE_HI = 3'd7;

  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 3'd7;

  typedef struct {
    cmd_t       command;
    logic [2:0] var_index;
    logic       last;
  } symbol_t;

  typedef struct {
    logic [DATA_W-1:0] value;
    status_t           code;
    logic [LEFT_W-1:0] left;
  } outcome_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [2:0] command = CMD_PUSH;
  logic [2:0] var_index = VAR_A;
  logic last = 1'b0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic signed [DATA_W-1:0] result_value;
  logic [1:0] status;
  logic [LEFT_W-1:0] leftover_entries;
  logic cfg_write = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [DATA_W-1:0] cfg_data = '0;

  symbol_t symbols_to_send[$];
  outcome_t results_due[$];
  int unsigned symbols_queued = 0;
  int unsigned mismatches = 0;
  int unsigned cycle_count = 0;
  int unsigned send_idle_pct = 0;
  int unsigned recv_idle_pct = 0;

  // Mirror of the evaluator state.
  logic [DATA_W-1:0] var_values[NUM_VARS];
  logic [DATA_W-1:0] operand_stack[STACK_DEPTH];
  int unsigned stack_count = 0;
  status_t sticky_status = ST_OK;

  prefix_expression_evaluator_unit #(.STACK_DEPTH(STACK_DEPTH)) uut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .command(command),
    .var_index(var_index),
    .last(last),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .result_value(result_value),
    .status(status),
    .leftover_entries(leftover_entries),
    .cfg_write(cfg_write),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always #5 clk = ~clk;

  function automatic void note_error(status_t code);
    if (sticky_status == ST_OK) begin
      sticky_status = code;
    end
  endfunction

  function automatic void push_operand(logic [DATA_W-1:0] v);
    if (stack_count >= STACK_DEPTH) begin
      note_error(ST_OVER);
    end else begin
      operand_stack[stack_count] = v;
      stack_count++;
    end
  endfunction

  function automatic logic [DATA_W-1:0] pop_operand();
    if (stack_count == 0) begin
      note_error(ST_UNDER);
      return '0;
    end
    stack_count--;
    return operand_stack[stack_count];
  endfunction

  function automatic logic [DATA_W-1:0] divide_toward_zero(logic [DATA_W-1:0] a,
                                                           logic [DATA_W-1:0] b);
    logic [DATA_W-1:0] mag_a;
    logic [DATA_W-1:0] mag_b;
    logic [DATA_W-1:0] quotient;
    if (b == '0) begin
      note_error(ST_DIVZ);
      return '0;
    end
    mag_a = a[DATA_W-1] ? (32'd0 - a) : a;
    mag_b = b[DATA_W-1] ? (32'd0 - b) : b;
    quotient = mag_a / mag_b;
    return (a[DATA_W-1] ^ b[DATA_W-1]) ? (32'd0 - quotient) : quotient;
  endfunction

  function automatic logic [DATA_W-1:0] power_wrapped(logic [DATA_W-1:0] base,
                                                      logic [DATA_W-1:0] ex);
    logic [DATA_W-1:0] acc;
    acc = 32'd1;
    if (ex[DATA_W-1] || ex == '0) begin
      return 32'd1;
    end
    while (ex != '0) begin
      if (ex[0]) begin
        acc = acc * base;
      end
      base = base * base;
      ex = ex >> 1;
    end
    return acc;
  endfunction

  // Applies one accepted request to the mirror state and files the result it produces.
  function automatic void evaluate_symbol(cmd_t cmd, logic [2:0] vi, logic is_last);
    logic [DATA_W-1:0] top_val;
    logic [DATA_W-1:0] below_val;
    logic [DATA_W-1:0] combined;
    outcome_t due;
    if (cmd == CMD_PUSH) begin
      push_operand(vi < NUM_VARS ? var_values[vi] : '0);
    end else if (cmd <= CMD_POW) begin
      top_val = pop_operand();
      below_val = pop_operand();
      case (cmd)
        CMD_ADD: combined = top_val + below_val;
        CMD_SUB: combined = top_val - below_val;
        CMD_MUL: combined = top_val * below_val;
        CMD_DIV: combined = divide_toward_zero(top_val, below_val);
        default: combined = power_wrapped(top_val, below_val);
      endcase
      push_operand(combined);
    end
    if (is_last) begin
      due.value = pop_operand();
      due.code = sticky_status;
      due.left = stack_count[LEFT_W-1:0];
      results_due.push_back(due);
      stack_count = 0;
      sticky_status = ST_OK;
    end
  endfunction

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // Request driver.
  always @(posedge clk) begin
    symbol_t upcoming;
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        evaluate_symbol(cmd_t'(command), var_index, last);
      end
      if (!in_valid || !in_stall) begin
        if (symbols_to_send.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
          upcoming = symbols_to_send.pop_front();
          in_valid <= 1'b1;
          command <= upcoming.command;
          var_index <= upcoming.var_index;
          last <= upcoming.last;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Result monitor.
  always @(posedge clk) begin
    outcome_t due;
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (results_due.size() == 0) begin
          $display("%0t: unexpected result: expected none, actual value %h status %0d left %0d",
                   $time, result_value, status, leftover_entries);
          mismatches++;
        end else begin
          due = results_due.pop_front();
          if (result_value !== due.value) begin
            $display("%0t: result_value expected %h actual %h", $time, due.value,
                     result_value);
            mismatches++;
          end
          if (status !== due.code) begin
            $display("%0t: status expected %0d actual %0d", $time, due.code, status);
            mismatches++;
          end
          if (leftover_entries !== due.left) begin
            $display("%0t: leftover_entries expected %0d actual %0d", $time, due.left,
                     leftover_entries);
            mismatches++;
          end
        end
      end
      out_stall <= ($urandom_range(0, 99) < recv_idle_pct);
    end
  end

  task automatic add_symbol(cmd_t cmd, logic [2:0] vi, logic is_last);
    symbol_t s;
    s.command = cmd;
    s.var_index = vi;
    s.last = is_last;
    symbols_to_send.push_back(s);
    symbols_queued++;
  endtask

  function automatic logic [2:0] pick_variable();
    if ($urandom_range(0, 9) == 0) begin
      return 3'($urandom_range(VAR_SPARE_LO, VAR_SPARE_HI));
    end
    return 3'($urandom_range(VAR_A, VAR_F));
  endfunction

  // Queues one well-formed expression, right to left. With pushes_first all operands
  // go on the stack before any operator, which is how the stack gets driven past full.
  task automatic add_expression(int unsigned operands, bit pushes_first);
    int unsigned to_push;
    int unsigned depth;
    bit do_push;
    to_push = operands;
    depth = 0;
    while (to_push != 0 || depth > 1) begin
      do_push = (to_push != 0) && (pushes_first || depth < 2 || $urandom_range(0, 1) == 1);
      if (do_push) begin
        add_symbol(CMD_PUSH, pick_variable(), to_push == 1 && depth == 0);
        to_push--;
        depth++;
      end else begin
        add_symbol(cmd_t'($urandom_range(CMD_ADD, CMD_POW)), 3'($urandom_range(0, 7)),
                   to_push == 0 && depth == 2);
        depth--;
      end
    end
  endtask

  task automatic write_register(logic [CFG_IDX_W-1:0] idx, logic [DATA_W-1:0] data);
    @(posedge clk);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    if (idx < NUM_VARS) begin
      var_values[idx] = data;
    end
    cfg_write <= 1'b0;
  endtask

  task automatic wait_until_idle();
    while (symbols_to_send.size() != 0 || in_valid || results_due.size() != 0) begin
      @(posedge clk);
    end
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  initial begin
    logic [DATA_W-1:0] extremes[NUM_VARS];
    logic [DATA_W-1:0] setting[NUM_VARS];
    int unsigned phase;
    int unsigned phase_start;
    int unsigned pick;
    int unsigned noise_len;

    extremes = '{32'h8000_0000, 32'h7fff_ffff, 32'h0000_0000, 32'hffff_ffff,
                 32'h0000_0001, 32'h0000_0002};
    foreach (var_values[i]) var_values[i] = '0;
    send_idle_pct = 6;
    recv_idle_pct = 49;

    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // A is the largest value, B the most negative, C zero, D minus one, E two
    // and F thirty-one.
    write_register(VAR_A, 32'h7fff_ffff);
    write_register(VAR_B, 32'h8000_0000);
    write_register(VAR_C, 32'h0000_0000);
    write_register(VAR_D, 32'hffff_ffff);
    write_register(VAR_E, 32'h0000_0002);
    write_register(VAR_F, 32'h0000_001f);

    // Most negative divided by minus one wraps.
    add_symbol(CMD_PUSH, VAR_D, 1'b0);
    add_symbol(CMD_PUSH, VAR_B, 1'b0);
    add_symbol(CMD_DIV, VAR_A, 1'b1);
    // Divide by zero.
    add_symbol(CMD_PUSH, VAR_C, 1'b0);
    add_symbol(CMD_PUSH, VAR_A, 1'b0);
    add_symbol(CMD_DIV, VAR_A, 1'b1);
    // Two to the thirty-first, then a negative exponent.
    add_symbol(CMD_PUSH, VAR_F, 1'b0);
    add_symbol(CMD_PUSH, VAR_E, 1'b0);
    add_symbol(CMD_POW, VAR_A, 1'b1);
    add_symbol(CMD_PUSH, VAR_D, 1'b0);
    add_symbol(CMD_PUSH, VAR_E, 1'b0);
    add_symbol(CMD_POW, VAR_A, 1'b1);
    // Operator on an empty stack, then a bare final pop with a spare code.
    add_symbol(CMD_ADD, VAR_A, 1'b1);
    add_symbol(CMD_SPARE_LO, VAR_SPARE_HI, 1'b1);
    // Spare variable indexes push zero.
    add_symbol(CMD_PUSH, VAR_SPARE_HI, 1'b0);
    add_symbol(CMD_PUSH, VAR_SPARE_LO, 1'b0);
    add_symbol(CMD_MUL, VAR_A, 1'b1);
    // Addition that wraps.
    add_symbol(CMD_PUSH, VAR_A, 1'b0);
    add_symbol(CMD_PUSH, VAR_A, 1'b0);
    add_symbol(CMD_ADD, VAR_A, 1'b1);
    // Underflow first, then divide by zero: the first error must stick.
    add_symbol(CMD_SUB, VAR_A, 1'b0);
    add_symbol(CMD_PUSH, VAR_C, 1'b0);
    add_symbol(CMD_DIV, VAR_A, 1'b1);
    // A spare code in the middle, and entries left behind after the final pop.
    add_symbol(CMD_PUSH, VAR_B, 1'b0);
    add_symbol(CMD_SPARE_HI, VAR_F, 1'b0);
    add_symbol(CMD_PUSH, VAR_C, 1'b1);
    wait_until_idle();

    write_register(REG_UNUSED, $urandom);

    for (phase = 0; phase < PHASES; phase++) begin
      case (phase / 3)
        0: begin
          send_idle_pct = 6;
          recv_idle_pct = 49;
        end
        1: begin
          send_idle_pct = 49;
          recv_idle_pct = 6;
        end
        default: begin
          send_idle_pct = 0;
          recv_idle_pct = 0;
        end
      endcase
      foreach (setting[i]) begin
        case (phase % 3)
          0: setting[i] = $urandom;
          1: setting[i] = 32'($urandom_range(0, 12)) - 32'd6;
          default: setting[i] = extremes[(i + phase) % NUM_VARS];
        endcase
        write_register(CFG_IDX_W'(i), setting[i]);
      end

      phase_start = symbols_queued;
      while (symbols_queued - phase_start < REQUESTS_PER_PHASE) begin
        pick = $urandom_range(0, 99);
        if (pick < 78) begin
          add_expression($urandom_range(1, 8), 1'b0);
        end else if (pick < 86) begin
          add_expression($urandom_range(2, 70), 1'b1);
        end else begin
          noise_len = $urandom_range(1, 6);
          repeat (noise_len) begin
            add_symbol(cmd_t'($urandom_range(0, 7)), 3'($urandom_range(0, 7)),
                       $urandom_range(0, 4) == 0);
          end
        end
      end
      // Close the phase so the stack is empty before the variables change.
      add_expression(1, 1'b0);
      wait_until_idle();
    end

    if (mismatches == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
